[rtl/fla_pkg.sv]
// Shared types and constants for the free-list slot allocator.
// No dependencies; imported by every module of the block.
`default_nettype none

package fla_pkg;

   localparam int SlotW   = 8;
   localparam int CountW  = 9;
   localparam int BlockW  = 13;
   localparam int OffsetW = 20;
   localparam int StatusW = 2;
   localparam int CsrAddrW = 3;
   localparam int CsrDataW = 32;
   localparam int LinkW   = SlotW + 1;   // link plus end-of-list flag

   localparam logic [CountW-1:0] SlotCountReset  = 9'd256;
   localparam logic [BlockW-1:0] BlockBytesReset = 13'd4;

   localparam logic REQ_ALLOC = 1'b0;
   localparam logic REQ_FREE  = 1'b1;

   localparam logic [StatusW-1:0] STATUS_OK    = 2'd0;
   localparam logic [StatusW-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [StatusW-1:0] STATUS_RANGE = 2'd2;

   localparam logic REG_SLOT_COUNT  = 1'b0;
   localparam logic REG_BLOCK_BYTES = 1'b1;

   typedef struct packed {
      logic [CountW-1:0] slot_count;
      logic [BlockW-1:0] block_bytes;
   } cfg_type;

endpackage

`default_nettype wire

[rtl/free_list_slot_allocator_core.sv]
// Free-list slot allocator: result in the cycle after a request is accepted.
// Free requests and fresh-slot allocations need no extra state; a freed-list
// allocation blocks new requests in ST_LINK while the new head is read back.
// Synchronous active-high reset empties the freed list, clears the fresh count
// and loads slot_count 256, block_bytes 4; the link memory is not cleared.
`default_nettype none

module free_list_slot_allocator_core
   import fla_pkg::*;
#(
   parameter int NUM_SLOTS = 256
) (
   input  wire logic                clock,
   input  wire logic                reset,
   // request
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   input  wire logic [7:0]          req_tdata,   // [7:0] free_slot
   input  wire logic                req_tuser,   // [0] req_type
   // response
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   output logic      [31:0]         rsp_tdata,   // [7:0] slot, [27:8] byte_offset
   output logic      [StatusW-1:0]  rsp_tuser,   // [1:0] status
   // configuration
   input  wire logic                csr_psel,
   input  wire logic                csr_penable,
   input  wire logic                csr_pwrite,
   input  wire logic [CsrAddrW-1:0] csr_paddr,
   input  wire logic [CsrDataW-1:0] csr_pwdata,
   output logic      [CsrDataW-1:0] csr_prdata,
   output logic                     csr_pready
);

   localparam int MemDepth = (NUM_SLOTS > 256) ? 256 : NUM_SLOTS;
   localparam int IdxW     = $clog2(MemDepth);
   localparam logic [CountW-1:0] CountCap = CountW'(MemDepth);

   typedef enum logic {ST_IDLE, ST_LINK} state_type;

   cfg_type cfg;

   state_type          state_ff, state_in;
   logic [SlotW-1:0]   freed_head_ff, freed_head_in;
   logic               freed_nonempty_ff, freed_nonempty_in;
   logic [CountW-1:0]  fresh_count_ff, fresh_count_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [SlotW-1:0]   rsp_slot_ff, rsp_slot_in;
   logic [OffsetW-1:0] rsp_offset_ff, rsp_offset_in;
   logic [StatusW-1:0] rsp_status_ff, rsp_status_in;

   logic [CountW-1:0]        eff_count;
   logic                     accept;
   logic [SlotW+BlockW-1:0]  product;
   logic                     rd_en, wr_en;
   logic [LinkW-1:0]         wr_data, rd_data;

   fla_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   fla_link_ram #(.DEPTH(MemDepth)) u_link_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (req_tdata[IdxW-1:0]),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (freed_head_ff[IdxW-1:0]),
      .rd_data (rd_data)
   );

   assign eff_count  = (cfg.slot_count > CountCap) ? CountCap : cfg.slot_count;
   assign req_tready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;
   assign wr_data    = {!freed_nonempty_ff, freed_head_ff};
   assign product    = rsp_slot_in * cfg.block_bytes;

   always_comb begin
      state_in          = state_ff;
      freed_head_in     = freed_head_ff;
      freed_nonempty_in = freed_nonempty_ff;
      fresh_count_in    = fresh_count_ff;
      rsp_valid_in      = rsp_valid_ff && !rsp_tready;
      rsp_slot_in       = '0;
      rsp_status_in     = STATUS_OK;
      rd_en             = 1'b0;
      wr_en             = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_valid_in = 1'b1;
               if (req_tuser == REQ_ALLOC) begin
                  priority if (freed_nonempty_ff) begin
                     rsp_slot_in = freed_head_ff;
                     rd_en       = 1'b1;
                     state_in    = ST_LINK;
                  end else if (fresh_count_ff < eff_count) begin
                     rsp_slot_in    = fresh_count_ff[SlotW-1:0];
                     fresh_count_in = fresh_count_ff + CountW'(1);
                  end else begin
                     rsp_status_in = STATUS_EMPTY;
                  end
               end else begin
                  if ({1'b0, req_tdata} < eff_count) begin
                     wr_en             = 1'b1;
                     freed_head_in     = req_tdata;
                     freed_nonempty_in = 1'b1;
                  end else begin
                     rsp_status_in = STATUS_RANGE;
                  end
               end
            end
         end
         ST_LINK: begin
            if (rd_data[LinkW-1]) begin
               freed_nonempty_in = 1'b0;
               freed_head_in     = '0;
            end else begin
               freed_head_in = rd_data[SlotW-1:0];
            end
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
      rsp_offset_in = product[OffsetW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_IDLE;
         freed_head_ff     <= '0;
         freed_nonempty_ff <= 1'b0;
         fresh_count_ff    <= '0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         state_ff          <= state_in;
         freed_head_ff     <= freed_head_in;
         freed_nonempty_ff <= freed_nonempty_in;
         fresh_count_ff    <= fresh_count_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
      if (accept) begin
         rsp_slot_ff   <= rsp_slot_in;
         rsp_offset_ff <= rsp_offset_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(32-OffsetW-SlotW){1'b0}}, rsp_offset_ff, rsp_slot_ff};
   assign rsp_tuser  = rsp_status_ff;

endmodule

`default_nettype wire

[rtl/fla_csr.sv]
// Configuration registers (slot count, block size) behind an APB-style port.
// Depends on fla_pkg.
`default_nettype none

module fla_csr
   import fla_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                psel,
   input  wire logic                penable,
   input  wire logic                pwrite,
   input  wire logic [CsrAddrW-1:0] paddr,
   input  wire logic [CsrDataW-1:0] pwdata,
   output logic      [CsrDataW-1:0] prdata,
   output logic                     pready,
   output cfg_type                  cfg
);

   logic [CountW-1:0] slot_count_ff;
   logic [BlockW-1:0] block_bytes_ff;
   logic              wr_en;
   logic              reg_sel;

   assign pready  = 1'b1;
   assign reg_sel = paddr[2];
   assign wr_en   = psel & penable & pwrite & pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_count_ff  <= SlotCountReset;
         block_bytes_ff <= BlockBytesReset;
      end else if (wr_en) begin
         unique case (reg_sel)
            REG_SLOT_COUNT:  slot_count_ff  <= pwdata[CountW-1:0];
            REG_BLOCK_BYTES: block_bytes_ff <= pwdata[BlockW-1:0];
            default:         slot_count_ff  <= slot_count_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_SLOT_COUNT:  prdata = {{(CsrDataW-CountW){1'b0}}, slot_count_ff};
         REG_BLOCK_BYTES: prdata = {{(CsrDataW-BlockW){1'b0}}, block_bytes_ff};
         default:         prdata = '0;
      endcase
   end

   assign cfg.slot_count  = slot_count_ff;
   assign cfg.block_bytes = block_bytes_ff;

endmodule

`default_nettype wire

[rtl/fla_link_ram.sv]
// Link memory of the freed list: one write port, one read port, registered read.
// Depends on fla_pkg for the word width.
`default_nettype none

module fla_link_ram
   import fla_pkg::*;
#(
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [LinkW-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [LinkW-1:0]         rd_data
);

   logic [LinkW-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

[rtl/fla_checker.sv]
// Port-level checks for the free-list slot allocator, bound to the top level.
// Depends on fla_pkg and free_list_slot_allocator_core.
`default_nettype none

module fla_checker
   import fla_pkg::*;
(
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_tvalid,
   input wire logic               req_tready,
   input wire logic               rsp_tvalid,
   input wire logic               rsp_tready,
   input wire logic [31:0]        rsp_tdata,
   input wire logic [StatusW-1:0] rsp_tuser
);

   // every accepted request gives its result on the next cycle
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> rsp_tvalid)
      else $error("no response after accepted request");

   // failed requests carry no slot and no offset
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != STATUS_OK) |-> (rsp_tdata == '0))
      else $error("failed request returned a slot");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser == STATUS_OK || rsp_tuser == STATUS_EMPTY ||
                      rsp_tuser == STATUS_RANGE))
      else $error("unknown status code");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response changed");

endmodule

bind free_list_slot_allocator_core fla_checker u_fla_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire
